/* rtl/ctt_pkg.sv */
// shared types, codes and constants of the countdown timer table
`timescale 1ns / 1ps
package ctt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int LIVE_W              = 5;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD  = 2'd0;
    localparam t_cmd CMD_DEL  = 2'd1;
    localparam t_cmd CMD_TICK = 2'd2;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ADDED     = 3'd0;
    localparam t_kind KIND_REJECTED  = 3'd1;
    localparam t_kind KIND_DEL_DONE  = 3'd2;
    localparam t_kind KIND_POST      = 3'd3;
    localparam t_kind KIND_TICK_DONE = 3'd4;

    // first tag character that makes an expiry post
    localparam logic [7:0] POST_CHAR = 8'h48;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] tag;
        logic [7:0]  queue_id;
        logic [7:0]  msg_id;
        logic [15:0] msg_param;
        logic [15:0] timeout;
    } t_in_beat;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        post_queue;
        logic [7:0]        post_id;
        logic [15:0]       post_param;
        logic [LIVE_W-1:0] live_count;
        logic              last;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  queue;
        logic [7:0]  msg_id;
        logic [15:0] param;
        logic [15:0] remaining;
    } t_entry;

endpackage

/* rtl/ctt_mem.sv */
// timer entry memory, one write and one registered read port
`timescale 1ns / 1ps
module ctt_mem #(
    parameter int TABLE_DEPTH = ctt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ctt_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ctt_pkg::t_entry o_rdata
);

    ctt_pkg::t_entry r_mem [TABLE_DEPTH];
    ctt_pkg::t_entry r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ctt_outq.sv */
// one-entry result register on the output channel
`timescale 1ns / 1ps
module ctt_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ctt_pkg::t_out_beat i_beat,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output ctt_pkg::t_out_beat o_beat
);

    logic               r_valid;
    ctt_pkg::t_out_beat r_beat;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_beat <= i_beat;
        end
    end

endmodule

/* rtl/countdown_timer_table_unit.sv */
// countdown timer table: sequencer over the entry memory, top level
`timescale 1ns / 1ps
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------
//  input    | i_in_valid / o_in_ready   | i_in_beat  (t_in_beat)
//  output   | o_out_valid / i_out_ready | o_out_beat (t_out_beat)
//
//  add: result goes straight to the output register
//  delete / tick: one entry per memory read; a kept entry passes read and evaluate,
//  a removed entry with a move from the tail passes read, evaluate and move,
//  and the closing beat follows the last entry of the walk
//  reset clears the live count, state, index and result valid; memory contents are not cleared
//  a full output register stalls the walk in place; input is taken only in idle
//
module countdown_timer_table_unit #(
    parameter int TABLE_DEPTH = ctt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ctt_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ctt_pkg::t_out_beat o_out_beat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_MOVE
    } t_state;

    t_state              r_state, n_state;
    ctt_pkg::t_cmd       r_cmd, n_cmd;
    logic [15:0]         r_tag, n_tag;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_idx, n_idx;

    // memory port
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    ctt_pkg::t_entry     mem_wdata, mem_rdata;

    // result path
    logic                out_free, push;
    ctt_pkg::t_out_beat  push_beat;
    logic [CW-1:0]       live_src;
    logic [CW+4:0]       live_ext;

    logic [CW-1:0]       tail;
    logic                in_acc, hit, post;

    assign tail     = r_total - CW'(1);
    assign live_ext = {5'd0, live_src};
    assign in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;

    // entry under evaluation: remove on tag match (delete) or zero count (tick)
    assign hit  = (r_cmd == ctt_pkg::CMD_DEL) ? (mem_rdata.tag == r_tag)
                                              : (mem_rdata.remaining == 16'd0);
    assign post = (r_cmd == ctt_pkg::CMD_TICK)
                  && (mem_rdata.tag[15:8] == ctt_pkg::POST_CHAR);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_tag     = r_tag;
        n_total   = r_total;
        n_idx     = r_idx;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_raddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        push      = 1'b0;
        live_src  = r_total;
        push_beat = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_beat.cmd)
                        ctt_pkg::CMD_ADD: begin
                            push           = 1'b1;
                            push_beat.last = 1'b1;
                            if (r_total >= CW'(TABLE_DEPTH)) begin
                                push_beat.kind = ctt_pkg::KIND_REJECTED;
                            end else begin
                                push_beat.kind      = ctt_pkg::KIND_ADDED;
                                mem_we              = 1'b1;
                                mem_waddr           = r_total[AW-1:0];
                                mem_wdata.tag       = i_in_beat.tag;
                                mem_wdata.queue     = i_in_beat.queue_id;
                                mem_wdata.msg_id    = i_in_beat.msg_id;
                                mem_wdata.param     = i_in_beat.msg_param;
                                mem_wdata.remaining = i_in_beat.timeout;
                                n_total             = r_total + CW'(1);
                                live_src            = r_total + CW'(1);
                            end
                        end
                        ctt_pkg::CMD_DEL, ctt_pkg::CMD_TICK: begin
                            n_cmd   = i_in_beat.cmd;
                            n_tag   = i_in_beat.tag;
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                        default: begin
                            // unused command: dropped, no beat
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_idx >= r_total) begin
                    // walk done: closing beat
                    if (out_free) begin
                        push           = 1'b1;
                        push_beat.kind = (r_cmd == ctt_pkg::CMD_DEL)
                                         ? ctt_pkg::KIND_DEL_DONE
                                         : ctt_pkg::KIND_TICK_DONE;
                        push_beat.last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!hit) begin
                    if (r_cmd == ctt_pkg::CMD_TICK) begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = mem_rdata.remaining - 16'd1;
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = S_RD;
                end else if (!post || out_free) begin
                    if (post) begin
                        push                 = 1'b1;
                        push_beat.kind       = ctt_pkg::KIND_POST;
                        push_beat.post_queue = mem_rdata.queue;
                        push_beat.post_id    = mem_rdata.msg_id;
                        push_beat.post_param = mem_rdata.param;
                        live_src             = tail;
                    end
                    n_total = tail;
                    if (r_idx == tail) begin
                        // tail entry itself: just drop it
                        n_state = S_RD;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = tail[AW-1:0];
                        n_state   = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                // tail entry lands in the freed slot and is examined next
                mem_we  = 1'b1;
                n_state = S_EVAL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        push_beat.live_count = live_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_idx   <= '0;
            r_cmd   <= ctt_pkg::CMD_ADD;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_cmd   <= n_cmd;
        end
        r_tag <= n_tag;
    end

    ctt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ctt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (push_beat),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

    // live count never passes the table depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(TABLE_DEPTH))
        else $error("live count above table depth");

    // posts come only out of a tick walk
    a_post_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (push_beat.kind == ctt_pkg::KIND_POST) |-> r_cmd == ctt_pkg::CMD_TICK)
        else $error("post beat outside tick");

    // a beat is only pushed into a free result register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result register overrun");

    // read and write never hit the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("memory read/write clash");

endmodule

/* dv/ctt_checker.sv */
// scoreboard for the countdown timer table: predicts every result beat and compares
`timescale 1ns / 1ps
module ctt_checker #(
    parameter int TABLE_DEPTH = ctt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ctt_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ctt_pkg::t_out_beat i_out_beat,
    output int                 o_fail_count,
    output int                 o_pending
);

    ctt_pkg::t_entry    timer_slots [TABLE_DEPTH];
    int                 live_total;
    ctt_pkg::t_out_beat awaited_beats [$];
    int                 mismatches;

    function automatic ctt_pkg::t_out_beat make_result(ctt_pkg::t_kind kind,
                                                       ctt_pkg::t_entry src,
                                                       logic last_flag);
        ctt_pkg::t_out_beat res;
        res = '0;
        res.kind = kind;
        if (kind == ctt_pkg::KIND_POST) begin
            res.post_queue = src.queue;
            res.post_id    = src.msg_id;
            res.post_param = src.param;
        end
        res.live_count = ctt_pkg::LIVE_W'(live_total);
        res.last       = last_flag;
        return res;
    endfunction

    // swap-remove: the tail entry fills the hole
    function automatic void drop_timer(int idx);
        int tail;
        tail = live_total - 1;
        if (idx != tail) begin
            timer_slots[idx] = timer_slots[tail];
        end
        live_total = tail;
    endfunction

    function automatic void predict_timer_results(ctt_pkg::t_in_beat cmd_beat);
        int              idx;
        ctt_pkg::t_entry gone;
        case (cmd_beat.cmd)
            ctt_pkg::CMD_ADD: begin
                if (live_total >= TABLE_DEPTH) begin
                    awaited_beats.push_back(make_result(ctt_pkg::KIND_REJECTED, '0, 1'b1));
                end else begin
                    timer_slots[live_total] = '{tag: cmd_beat.tag, queue: cmd_beat.queue_id,
                                               msg_id: cmd_beat.msg_id,
                                               param: cmd_beat.msg_param,
                                               remaining: cmd_beat.timeout};
                    live_total++;
                    awaited_beats.push_back(make_result(ctt_pkg::KIND_ADDED, '0, 1'b1));
                end
            end
            ctt_pkg::CMD_DEL: begin
                idx = 0;
                while (idx < live_total) begin
                    if (timer_slots[idx].tag == cmd_beat.tag) begin
                        drop_timer(idx);
                    end else begin
                        idx++;
                    end
                end
                awaited_beats.push_back(make_result(ctt_pkg::KIND_DEL_DONE, '0, 1'b1));
            end
            ctt_pkg::CMD_TICK: begin
                idx = 0;
                while (idx < live_total) begin
                    if (timer_slots[idx].remaining != 16'd0) begin
                        timer_slots[idx].remaining--;
                        idx++;
                    end else begin
                        // moved entry lands in idx and is looked at next
                        gone = timer_slots[idx];
                        drop_timer(idx);
                        if (gone.tag[15:8] == ctt_pkg::POST_CHAR) begin
                            awaited_beats.push_back(make_result(ctt_pkg::KIND_POST, gone,
                                                                1'b0));
                        end
                    end
                end
                awaited_beats.push_back(make_result(ctt_pkg::KIND_TICK_DONE, '0, 1'b1));
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin : watch
        ctt_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_beats.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with none expected", i_out_beat));
                end else begin
                    want = awaited_beats.pop_front();
                    check_field("kind", 16'(i_out_beat.kind), 16'(want.kind));
                    check_field("post_queue", 16'(i_out_beat.post_queue), 16'(want.post_queue));
                    check_field("post_id", 16'(i_out_beat.post_id), 16'(want.post_id));
                    check_field("post_param", i_out_beat.post_param, want.post_param);
                    check_field("live_count", 16'(i_out_beat.live_count), 16'(want.live_count));
                    check_field("last", 16'(i_out_beat.last), 16'(want.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_timer_results(i_in_beat);
            end
        end
        o_pending    <= awaited_beats.size();
        o_fail_count <= mismatches;
    end

endmodule

/* dv/countdown_timer_table_unit_tb.sv */
// testbench top for the countdown timer table: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps
module countdown_timer_table_unit_tb;

    // cmd code the block ignores
    localparam ctt_pkg::t_cmd CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 60;    // settle time before the verdict
    localparam int PHASE_ITEMS    = 62;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    ctt_pkg::t_in_beat  in_beat   = '0;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ctt_pkg::t_out_beat out_beat;
    int                 fail_count;
    int                 pending;

    // idle / stall rates in percent and hold requests, written only by the stimulus process
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;

    // receiver-side hold bookkeeping
    int holds_served = 0;
    int hold_left    = 0;

    int quiet_cycles = 0;

    // recently added tags, so that deletes mostly hit live entries
    bit [15:0] recent_tags [8];
    bit [2:0]  tag_slot = '0;

    countdown_timer_table_unit #(
        .TABLE_DEPTH(ctt_pkg::DEFAULT_TABLE_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_beat (out_beat)
    );

    ctt_checker #(
        .TABLE_DEPTH(ctt_pkg::DEFAULT_TABLE_DEPTH)
    ) timer_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_beat  (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic ctt_pkg::t_in_beat make_cmd(ctt_pkg::t_cmd cmd, logic [15:0] tag,
                                                   logic [7:0] queue_id, logic [7:0] msg_id,
                                                   logic [15:0] prm, logic [15:0] tmo);
        ctt_pkg::t_in_beat b;
        b.cmd       = cmd;
        b.tag       = tag;
        b.queue_id  = queue_id;
        b.msg_id    = msg_id;
        b.msg_param = prm;
        b.timeout   = tmo;
        return b;
    endfunction

    // tags cluster on a few 'H' and non-'H' values so deletes match several entries
    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return {ctt_pkg::POST_CHAR, 6'd0, 2'($urandom_range(3))};
        end else if (r < 70) begin
            return {8'($urandom), 6'd0, 2'($urandom_range(3))};
        end
        return 16'($urandom);
    endfunction

    // mostly short timeouts so entries expire within a few ticks
    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return 16'($urandom_range(3));
        end else if (r < 90) begin
            return 16'($urandom_range(20));
        end
        return 16'($urandom);
    endfunction

    function automatic ctt_pkg::t_in_beat random_add();
        ctt_pkg::t_in_beat b;
        b = make_cmd(ctt_pkg::CMD_ADD, pick_tag(), 8'($urandom), 8'($urandom), 16'($urandom),
                     pick_timeout());
        recent_tags[tag_slot] = b.tag;
        tag_slot = tag_slot + 3'd1;
        return b;
    endfunction

    function automatic ctt_pkg::t_in_beat random_command();
        ctt_pkg::t_in_beat b;
        int                r;
        r = $urandom_range(99);
        if (r < 50) begin
            return random_add();
        end
        // unused fields stay random so every payload bit toggles
        b = make_cmd(ctt_pkg::CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom));
        if (r >= 95) begin
            b.cmd = CMD_UNUSED;
        end else if (r >= 78) begin
            b.cmd = ctt_pkg::CMD_DEL;
            b.tag = ($urandom_range(4) != 0) ? recent_tags[3'($urandom_range(7))]
                                             : pick_tag();
        end
        return b;
    endfunction

    // offers one beat; valid stays up after acceptance unless the next call idles
    task automatic send_beat(input ctt_pkg::t_in_beat b);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random traffic; ignored commands are not counted
    task automatic run_phase(input int n_items);
        int                sent;
        ctt_pkg::t_in_beat b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(24) == 0) begin
                // burst of adds to push the table toward full
                repeat (10) begin
                    send_beat(random_add());
                    sent++;
                end
            end else begin
                b = random_command();
                send_beat(b);
                if (b.cmd != CMD_UNUSED) begin
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, silent and posting expiries, moved-entry re-check
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'd1));
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'h4858, 8'hFF, 8'hFF, 16'hFFFF, 16'd0));
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'h4100, 8'h55, 8'hAA, 16'h1234, 16'd0));
        // 'H' entry posts, tail 'A' entry moves in and expires silently
        send_beat(make_cmd(ctt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000));
        // delete with no match leaves the table alone
        send_beat(make_cmd(ctt_pkg::CMD_DEL, 16'h1234, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_beat(make_cmd(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_cmd(ctt_pkg::CMD_DEL, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 16'h0000));
        send_beat(make_cmd(ctt_pkg::CMD_DEL, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000));
        // expiry in the last slot: dropped with nothing moved
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'h48FF, 8'h01, 8'h02, 16'h0003, 16'd3));
        send_beat(make_cmd(ctt_pkg::CMD_ADD, 16'h4801, 8'h80, 8'h7F, 16'h8000, 16'd0));
        send_beat(make_cmd(ctt_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        // fill to full, then one add that must be rejected
        repeat (15) send_beat(random_add());
        send_beat(random_add());
        wait_drained();

        // no idling; receiver holds off while the sender keeps offering
        hold_requests <= hold_requests + 1;
        run_phase(PHASE_ITEMS);
        wait_drained();

        // sender mostly idle
        sender_idle_pct <= 81;
        run_phase(PHASE_ITEMS);
        wait_drained();

        // receiver mostly stalled
        sender_idle_pct <= 0;
        recv_stall_pct  <= 81;
        run_phase(PHASE_ITEMS);
        wait_drained();

        // both sides idling
        sender_idle_pct <= 35;
        recv_stall_pct  <= 35;
        run_phase(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
